@@ design/nre_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nre_pkg
// shared types and constants of the nuclear repulsion energy accumulator
// ----------------------------------------------------------------------------
package nre_pkg;

	localparam int MAX_ATOMS        = 256;
	localparam int COORD_FRAC_BITS  = 16;
	localparam int ENERGY_FRAC_BITS = 24;
	localparam int ADDR_W           = $clog2(MAX_ATOMS);
	localparam int CNT_W            = $clog2(MAX_ATOMS + 1);
	localparam int SHIFT            = ENERGY_FRAC_BITS + COORD_FRAC_BITS;
	localparam int ROOT_BITS        = 34;
	localparam int SQ_W             = 66;
	localparam int DIV_STEPS        = SHIFT + 14;
	localparam logic [47:0] ENERGY_MAX = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic [6:0]         charge;
		logic               last_atom;
	} atom_in_t;

	typedef struct packed {
		logic [47:0] energy;
		logic [8:0]  atoms_seen;
		logic        is_total;
		logic        saturated;
		logic        coincident;
		logic        capacity_exceeded;
	} energy_out_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [6:0]         charge;
	} atom_entry_t;

endpackage
`default_nettype wire

@@ design/nuclear_repulsion_energy_sum_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nuclear_repulsion_energy_sum_top
// pairs each new atom with every stored atom and sums Zi*Zj/r into Q24.24
// ----------------------------------------------------------------------------
// schedule: per stored atom one memory read, the difference and magnitude
//   states, the squares sum, 34 root steps, 54 divide steps and one accumulate
//   (a coincident pair skips the divide), plus the idle and done states per item
// intake: a new item is taken only once the previous one is through; the pace is
//   set by the shared one-bit-per-cycle root and divide loops behind the single memory read port
// reset: arst_n clears count, sum, flags and control; the atom memory holds
//   no reset and entries are read only after being written
module nuclear_repulsion_energy_sum_top
	import nre_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire atom_in_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output energy_out_t      out_data
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_SQ1, ST_SQ2, ST_ROOT, ST_DIV, ST_ACC, ST_DONE
	} state_t;

	state_t state_q;

	// atom store, one synchronous memory
	atom_entry_t mem [MAX_ATOMS];
	atom_entry_t rd_q;
	logic [ADDR_W-1:0] rd_addr;
	logic rd_en, wr_en;

	atom_in_t   cur_q;
	logic [CNT_W-1:0] count_q, idx_q;
	logic [47:0] sum_q;
	logic sat_q, coin_q, cap_q;

	// pair datapath registers
	logic [32:0] dx_q, dy_q, dz_q;
	logic [SQ_W-1:0] sq_q;
	logic [32:0] sqx_q, sqy_q, sqz_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [SQ_W-1:0] rrem_q;
	logic [5:0] step_q;
	logic [13:0] pz_q;
	logic [ROOT_BITS-1:0] drem_q;
	logic [48:0] quo_q;
	logic over_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[count_q[ADDR_W-1:0]] <= '{x: cur_q.coord_x, y: cur_q.coord_y,
				z: cur_q.coord_z, charge: cur_q.charge};
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	assign rd_addr  = idx_q[ADDR_W-1:0];
	assign in_ready = (state_q == ST_IDLE);

	// store the atom at the edge that hands its result to the output register, unless the store is full
	assign wr_en = (state_q == ST_DONE) && (!out_valid || out_ready)
		&& (count_q != CNT_W'(MAX_ATOMS));

	// root: digit recurrence, two radicand bits a step
	logic [SQ_W+1:0] r_trial, r_next, sq_ext;
	logic [1:0] r_pair;
	always_comb begin
		sq_ext  = {2'b00, sq_q};
		r_pair  = sq_ext[2*step_q[5:0] +: 2];
		r_next  = {rrem_q, r_pair};
		r_trial = {{(SQ_W-ROOT_BITS){1'b0}}, root_q, 2'b01};
	end

	// divide: restoring, one quotient bit a step
	logic [ROOT_BITS:0] d_shift;
	logic d_bit;
	always_comb begin
		d_bit   = (step_q >= 6'(SHIFT)) ? pz_q[4'(step_q - 6'(SHIFT))] : 1'b0;
		d_shift = {drem_q, d_bit};
	end

	logic [48:0] sum_ext;
	assign sum_ext = {1'b0, sum_q} + quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			count_q   <= '0;
			sum_q     <= '0;
			sat_q     <= 1'b0;
			coin_q    <= 1'b0;
			cap_q     <= 1'b0;
			idx_q     <= '0;
			rd_en     <= 1'b0;
		end else begin
			rd_en <= 1'b0;
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cur_q <= in_data;
						idx_q <= '0;
						if (count_q == CNT_W'(MAX_ATOMS)) begin
							cap_q   <= 1'b1;
							state_q <= ST_DONE;
						end else if (count_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							rd_en   <= 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: state_q <= ST_SQ1; // memory read data lands
				ST_SQ1: begin
					dx_q <= 33'($signed({cur_q.coord_x[31], cur_q.coord_x})
						- $signed({rd_q.x[31], rd_q.x}));
					dy_q <= 33'($signed({cur_q.coord_y[31], cur_q.coord_y})
						- $signed({rd_q.y[31], rd_q.y}));
					dz_q <= 33'($signed({cur_q.coord_z[31], cur_q.coord_z})
						- $signed({rd_q.z[31], rd_q.z}));
					pz_q <= cur_q.charge * rd_q.charge;
					state_q <= ST_SQ2;
				end
				ST_SQ2: begin
					// magnitudes of the differences
					sqx_q <= 33'($signed(dx_q) < 0 ? -$signed(dx_q) : $signed(dx_q));
					sqy_q <= 33'($signed(dy_q) < 0 ? -$signed(dy_q) : $signed(dy_q));
					sqz_q <= 33'($signed(dz_q) < 0 ? -$signed(dz_q) : $signed(dz_q));
					state_q <= ST_ROOT;
					step_q  <= 6'(ROOT_BITS);
				end
				ST_ROOT: begin
					if (step_q == 6'(ROOT_BITS)) begin
						// first root cycle forms the squares sum
						sq_q   <= sqx_q * sqx_q + sqy_q * sqy_q + sqz_q * sqz_q;
						root_q <= '0;
						rrem_q <= '0;
						step_q <= 6'(ROOT_BITS - 1);
					end else begin
						if (r_next >= r_trial) begin
							rrem_q <= SQ_W'(r_next - r_trial);
							root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
						end else begin
							rrem_q <= SQ_W'(r_next);
							root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
						end
						if (step_q == '0) begin
							if (sq_q == '0) begin
								coin_q  <= 1'b1;
								state_q <= ST_ACC;
							end else begin
								state_q <= ST_DIV;
							end
							drem_q <= '0;
							quo_q  <= '0;
							over_q <= 1'b0;
							step_q <= 6'(DIV_STEPS - 1);
						end else begin
							step_q <= step_q - 6'd1;
						end
					end
				end
				ST_DIV: begin
					if (!over_q) begin
						if (d_shift >= {1'b0, root_q}) begin
							drem_q <= ROOT_BITS'(d_shift - {1'b0, root_q});
							quo_q  <= {quo_q[47:0], 1'b1};
							if ({quo_q[47:0], 1'b1} > {1'b0, ENERGY_MAX}) over_q <= 1'b1;
						end else begin
							drem_q <= ROOT_BITS'(d_shift);
							quo_q  <= {quo_q[47:0], 1'b0};
							if ({quo_q[47:0], 1'b0} > {1'b0, ENERGY_MAX}) over_q <= 1'b1;
						end
					end
					if (step_q == '0)
						state_q <= ST_ACC;
					else
						step_q <= step_q - 6'd1;
				end
				ST_ACC: begin
					if (sq_q != '0) begin
						if (over_q || sum_ext > {1'b0, ENERGY_MAX}) begin
							sum_q <= ENERGY_MAX;
							sat_q <= 1'b1;
						end else begin
							sum_q <= sum_ext[47:0];
						end
					end
					if (idx_q + 1'b1 == count_q) begin
						state_q <= ST_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						rd_en   <= 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					// wait for the output register to free up
					if (!out_valid || out_ready) begin
						logic [CNT_W-1:0] n;
						n = (count_q == CNT_W'(MAX_ATOMS)) ? count_q : count_q + 1'b1;
						out_valid <= 1'b1;
						out_data  <= '{energy: sum_q, atoms_seen: 9'(n),
							is_total: cur_q.last_atom, saturated: sat_q,
							coincident: coin_q, capacity_exceeded: cap_q};
						if (cur_q.last_atom) begin
							count_q <= '0;
							sum_q   <= '0;
							sat_q   <= 1'b0;
							coin_q  <= 1'b0;
							cap_q   <= 1'b0;
						end else begin
							count_q <= n;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
